@@ rtl/mrf_pkg.sv @@
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

    // Frame geometry
    localparam int BODY_MAX    = 11;
    localparam int LEN_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    // Constants of the frame and the CRC
    localparam logic [7:0]  SLAVE_RESET    = 8'h01;
    localparam logic [7:0]  FUNC_WRITE_ONE = 8'h06;
    localparam logic [7:0]  FUNC_WRITE_MUL = 8'h10;
    localparam logic [7:0]  FUNC_READ      = 8'h03;
    localparam logic [7:0]  COUNT_ONE      = 8'h01;
    localparam logic [7:0]  COUNT_TWO      = 8'h02;
    localparam logic [7:0]  BYTE_COUNT_TWO = 8'h04;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd6;
    localparam logic [LEN_W-1:0] LEN_LONG  = 4'd11;

    // Request modes
    typedef enum logic [1:0] {
        MODE_WRITE_ONE = 2'd0,
        MODE_WRITE_TWO = 2'd1,
        MODE_READ_ONE  = 2'd2,
        MODE_READ_TWO  = 2'd3
    } mode_t;

    // Classified request: frame body without CRC, first byte at index 0
    typedef struct packed {
        logic [BODY_MAX-1:0][7:0] body;
        logic [LEN_W-1:0]         body_len;
    } cmd_t;

    // Fold one byte into the CRC, LSB first, reflected polynomial
    function automatic logic [15:0] crc_update(input logic [15:0] acc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/mrf_if.sv @@
// ----------------------------------------------------------------------------
// mrf_if
// Valid/ready channels of the framer: the request channel and the frame
// byte channel.
// ----------------------------------------------------------------------------
interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] register_address;
    logic [31:0] write_value;

    modport source (output valid, output mode, output register_address,
                    output write_value, input ready);
    modport sink   (input valid, input mode, input register_address,
                    input write_value, output ready);
endinterface

interface mrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

@@ rtl/mrf_front.sv @@
// ----------------------------------------------------------------------------
// mrf_front
// Accepts request beats and classifies them into a frame body: function
// code, address, count fields and payload bytes, plus the body length.
// ----------------------------------------------------------------------------
module mrf_front
(
    mrf_req_if.sink          req,
    input  logic [7:0]       slave_address,
    input  logic             queue_full,
    output logic             push,
    output mrf_pkg::cmd_t    cmd
);

    mrf_pkg::mode_t mode;
    logic [15:0]    lo_w;
    logic [15:0]    hi_w;

    assign mode     = mrf_pkg::mode_t'(req.mode);
    assign lo_w     = req.write_value[15:0];
    assign hi_w     = req.write_value[31:16];
    assign req.ready = ~queue_full;
    assign push     = req.valid & ~queue_full;

    // Build the frame body for the selected mode
    always_comb
    begin
        cmd.body     = '0;
        cmd.body[0]  = slave_address;
        cmd.body[2]  = req.register_address[15:8];
        cmd.body[3]  = req.register_address[7:0];
        cmd.body_len = mrf_pkg::LEN_SHORT;
        case (mode)
            mrf_pkg::MODE_WRITE_ONE:
            begin
                cmd.body[1] = mrf_pkg::FUNC_WRITE_ONE;
                cmd.body[4] = lo_w[15:8];
                cmd.body[5] = lo_w[7:0];
            end
            mrf_pkg::MODE_WRITE_TWO:
            begin
                cmd.body[1]  = mrf_pkg::FUNC_WRITE_MUL;
                cmd.body[4]  = 8'h00;
                cmd.body[5]  = mrf_pkg::COUNT_TWO;
                cmd.body[6]  = mrf_pkg::BYTE_COUNT_TWO;
                cmd.body[7]  = lo_w[15:8];
                cmd.body[8]  = lo_w[7:0];
                cmd.body[9]  = hi_w[15:8];
                cmd.body[10] = hi_w[7:0];
                cmd.body_len = mrf_pkg::LEN_LONG;
            end
            mrf_pkg::MODE_READ_ONE:
            begin
                cmd.body[1] = mrf_pkg::FUNC_READ;
                cmd.body[4] = 8'h00;
                cmd.body[5] = mrf_pkg::COUNT_ONE;
            end
            default:
            begin
                cmd.body[1] = mrf_pkg::FUNC_READ;
                cmd.body[4] = 8'h00;
                cmd.body[5] = mrf_pkg::COUNT_TWO;
            end
        endcase
    end

endmodule

@@ rtl/mrf_queue.sv @@
// ----------------------------------------------------------------------------
// mrf_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module mrf_queue
#(
    parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mrf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output mrf_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrf_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ rtl/mrf_back.sv @@
// ----------------------------------------------------------------------------
// mrf_back
// Walks the head request byte by byte, folds each body byte into the CRC,
// appends the CRC low and high bytes and drives the output register.
// ----------------------------------------------------------------------------
module mrf_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  mrf_pkg::cmd_t head,
    output logic          pop,
    mrf_byte_if.source    frame
);

    logic [mrf_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic [15:0]               crc_reg, crc_next;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_byte_reg, out_byte_next;
    logic                      out_last_reg, out_last_next;
    logic                      step;
    logic                      in_body;
    logic                      at_crc_hi;
    logic [7:0]                body_byte;

    assign step      = head_valid & (~out_valid_reg | frame.ready);
    assign in_body   = (idx_reg < head.body_len);
    assign at_crc_hi = (idx_reg == mrf_pkg::LEN_W'(head.body_len + 4'd1));
    assign body_byte = head.body[idx_reg];
    assign pop       = step & at_crc_hi;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.last_byte  = out_last_reg;

    // Select the next beat and update the CRC
    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = frame.ready ? 1'b0 : out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            if (in_body)
            begin
                out_byte_next = body_byte;
                out_last_next = 1'b0;
                crc_next      = mrf_pkg::crc_update(crc_reg, body_byte);
                idx_next      = idx_reg + 1'b1;
            end
            else if (!at_crc_hi)
            begin
                out_byte_next = crc_reg[7:0];
                out_last_next = 1'b0;
                idx_next      = idx_reg + 1'b1;
            end
            else
            begin
                out_byte_next = crc_reg[15:8];
                out_last_next = 1'b1;
                crc_next      = mrf_pkg::CRC_INIT;
                idx_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= mrf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ rtl/modbus_rtu_request_framer.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Turns register requests into Modbus RTU master frames with CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   req   : one beat per request (mode, register_address, write_value).
//   frame : one beat per frame byte in transmit order; last_byte marks the
//           CRC high byte. Writes give 8 or 13 beats, reads 8 beats.
//   cfg_we / cfg_data : write slave_address (reset value 1) while idle.
// Throughput: one frame byte per cycle while frame.ready is high; the
//   byte sequencer emits one byte per cycle and folds each body byte into
//   the CRC. A request beat is stored in the queue and its bytes leave
//   through the output register. A queue of QUEUE_DEPTH requests lets
//   new requests enter while a frame is going out; frames follow back to back.
// Reset: queue empties, output goes invalid, slave_address returns to 1.
// Stall: when frame.ready is low the current byte holds; once the queue is
//   full req.ready drops.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer
#(
    parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    mrf_req_if.sink    req,
    mrf_byte_if.source frame,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    logic [7:0]    slave_address_reg;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          head_valid;
    mrf_pkg::cmd_t push_cmd;
    mrf_pkg::cmd_t head;

    // Hold the slave address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_address_reg <= mrf_pkg::SLAVE_RESET;
        else if (cfg_we)
            slave_address_reg <= cfg_data;
    end

    mrf_front u_front
    (
        .req           (req),
        .slave_address (slave_address_reg),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    mrf_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (head_valid),
        .head      (head)
    );

    mrf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .frame      (frame)
    );

endmodule

@@ bench/tb_modbus_rtu_request_framer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_framer
// Self-checking bench for the Modbus RTU request framer. Requests go in from a
// queue through a randomly idling driver; each accepted request is framed by a
// local model (function code, payload, CRC-16) and the frame bytes are checked
// beat by beat against the output channel, under random stalls, one long
// output hold-off and several slave address settings.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_request_framer;

    import mrf_pkg::*;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] register_address;
        logic [31:0] write_value;
    } register_request_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    localparam int LONG_HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    mrf_req_if  req_ch ();
    mrf_byte_if frame_ch ();

    modbus_rtu_request_framer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .frame    (frame_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    register_request_t pending_requests[$];
    frame_beat_t       expected_frame_bytes[$];
    register_request_t offered_request;

    logic [7:0] slave_address_copy;
    bit         idle_enable;
    bit         hold_trigger;
    bit         hold_started;
    int         hold_left;
    int         error_count   = 0;
    int         bytes_checked = 0;
    int         slave_settings;
    int         mode_count[4] = '{0, 0, 0, 0};

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Fold one byte into a Modbus CRC-16, bit by bit from the LSB
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = acc ^ {8'h00, data};
        repeat (8)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // Build the frame of one request and queue its bytes as expected beats
    function automatic void frame_request(input register_request_t r);
        logic [7:0]  body[$];
        logic [15:0] crc;
        body.push_back(slave_address_copy);
        case (r.mode)
            MODE_WRITE_ONE: body.push_back(FUNC_WRITE_ONE);
            MODE_WRITE_TWO: body.push_back(FUNC_WRITE_MUL);
            default:        body.push_back(FUNC_READ);
        endcase
        body.push_back(r.register_address[15:8]);
        body.push_back(r.register_address[7:0]);
        case (r.mode)
            MODE_WRITE_ONE:
            begin
                body.push_back(r.write_value[15:8]);
                body.push_back(r.write_value[7:0]);
            end
            MODE_WRITE_TWO:
            begin
                body.push_back(8'h00);
                body.push_back(COUNT_TWO);
                body.push_back(BYTE_COUNT_TWO);
                body.push_back(r.write_value[15:8]);
                body.push_back(r.write_value[7:0]);
                body.push_back(r.write_value[31:24]);
                body.push_back(r.write_value[23:16]);
            end
            MODE_READ_ONE:
            begin
                body.push_back(8'h00);
                body.push_back(COUNT_ONE);
            end
            default:
            begin
                body.push_back(8'h00);
                body.push_back(COUNT_TWO);
            end
        endcase
        crc = CRC_INIT;
        foreach (body[i])
        begin
            crc = crc16_fold(crc, body[i]);
            expected_frame_bytes.push_back('{value: body[i], last: 1'b0});
        end
        expected_frame_bytes.push_back('{value: crc[7:0], last: 1'b0});
        expected_frame_bytes.push_back('{value: crc[15:8], last: 1'b1});
    endfunction

    // Request driver: advance on each accepted beat, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid            <= 1'b0;
            req_ch.mode             <= MODE_WRITE_ONE;
            req_ch.register_address <= 16'h0000;
            req_ch.write_value      <= 32'h0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
            begin
                frame_request(offered_request);
                mode_count[offered_request.mode]++;
            end
            if (pending_requests.size() != 0 &&
                !(idle_enable && $urandom_range(99) < 20))
            begin
                offered_request          = pending_requests.pop_front();
                req_ch.valid            <= 1'b1;
                req_ch.mode             <= offered_request.mode;
                req_ch.register_address <= offered_request.register_address;
                req_ch.write_value      <= offered_request.write_value;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Count the long receiver hold-off once it is asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_started <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_trigger && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_left    <= LONG_HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Frame byte monitor: check each beat, then pick the next ready
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                bytes_checked++;
                if (expected_frame_bytes.size() == 0)
                begin
                    $error("frame_byte 0x%02h arrived with nothing expected",
                           frame_ch.frame_byte);
                    error_count++;
                end
                else
                begin
                    want = expected_frame_bytes.pop_front();
                    if (frame_ch.frame_byte !== want.value)
                    begin
                        $error("frame_byte: expected 0x%02h, got 0x%02h",
                               want.value, frame_ch.frame_byte);
                        error_count++;
                    end
                    if (frame_ch.last_byte !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b",
                               want.last, frame_ch.last_byte);
                        error_count++;
                    end
                end
            end
            // Hold ready low through the long hold-off
            if (hold_left > 0)
            begin
                frame_ch.ready <= 1'b0;
            end
            else
            begin
                frame_ch.ready <= !(idle_enable && $urandom_range(99) < 20);
            end
        end
    end

    task automatic push_request(input mode_t mode, input logic [15:0] addr,
                                input logic [31:0] value);
        pending_requests.push_back('{mode: mode, register_address: addr,
                                     write_value: value});
    endtask

    // Hold the sender until every queued request is framed and checked
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || req_ch.valid ||
               expected_frame_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slave_address(input logic [7:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        slave_address_copy = value;
        slave_settings++;
    endtask

    // Random request: mostly random fields, with some edge addresses and values
    task automatic push_random_request();
        logic [15:0] addr;
        logic [31:0] value;
        case ($urandom_range(9))
            0:       addr = 16'h0000;
            1:       addr = 16'hFFFF;
            default: addr = 16'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(9))
            0:       value = 32'h0;
            1:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
        endcase
        push_request(mode_t'($urandom_range(3)), addr, value);
    endtask

    // Stimulus
    initial
    begin
        logic [7:0] phase_slave[8];
        bit         frames_missing;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_data           = 8'h00;
        slave_address_copy = SLAVE_RESET;
        idle_enable        = 1'b1;
        hold_trigger       = 1'b0;
        frames_missing     = 1'b0;
        slave_settings     = 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset slave address, every mode at the field extremes
        push_request(MODE_WRITE_ONE, 16'h0000, 32'h0000_0000);
        push_request(MODE_WRITE_ONE, 16'hFFFF, 32'hFFFF_FFFF);
        push_request(MODE_WRITE_ONE, 16'h1234, 32'hFFFF_0000);
        push_request(MODE_WRITE_ONE, 16'h8001, 32'h0000_FFFF);
        push_request(MODE_WRITE_TWO, 16'h0000, 32'h0000_0000);
        push_request(MODE_WRITE_TWO, 16'hFFFF, 32'hFFFF_FFFF);
        push_request(MODE_WRITE_TWO, 16'hA55A, 32'h1234_5678);
        push_request(MODE_READ_ONE,  16'h0000, 32'h0000_0000);
        push_request(MODE_READ_ONE,  16'hFFFF, 32'hFFFF_FFFF);
        push_request(MODE_READ_TWO,  16'h0000, 32'hFFFF_FFFF);
        push_request(MODE_READ_TWO,  16'hFFFF, 32'h0000_0000);
        wait_for_drain();

        // Directed: lowest and highest slave address, the latter out of range
        write_slave_address(8'h00);
        for (int m = 0; m < 4; m++)
            push_request(mode_t'(m), 16'h00FF, 32'hFF00_FF00);
        wait_for_drain();
        write_slave_address(8'hFF);
        for (int m = 0; m < 4; m++)
            push_request(mode_t'(m), 16'hFF00, 32'h00FF_00FF);
        wait_for_drain();

        // Random phases, each under its own slave address
        phase_slave = '{8'd247, 8'h01, 8'hF8, 8'($urandom_range(247)), 8'h00,
                        8'hFF, 8'($urandom_range(255)), 8'($urandom_range(247))};
        for (int p = 0; p < 8; p++)
        begin
            write_slave_address(phase_slave[p]);
            idle_enable = (p != 2);
            if (p == 4)
                hold_trigger = 1'b1;
            repeat (55) push_random_request();
            wait_for_drain();
        end

        // Drain what is left, with a bound
        idle_enable = 1'b1;
        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        for (int i = 0; i < 5000 && expected_frame_bytes.size() != 0; i++)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (expected_frame_bytes.size() != 0)
        begin
            $error("%0d expected frame bytes never arrived",
                   expected_frame_bytes.size());
            frames_missing = 1'b1;
        end

        $display("Framed %0d write-one, %0d write-two, %0d read-one, %0d read-two requests",
                 mode_count[MODE_WRITE_ONE], mode_count[MODE_WRITE_TWO],
                 mode_count[MODE_READ_ONE], mode_count[MODE_READ_TWO]);
        $display("Checked %0d frame bytes over %0d slave address settings, %0d errors",
                 bytes_checked, slave_settings, error_count);
        if (error_count == 0 && !frames_missing)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout waiting for frame bytes");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
